FILE: rtl/core/phca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phca_pkg
// Shared types, codes and character helpers for the profile HMM count
// accumulator.
// ----------------------------------------------------------------------------
package phca_pkg;

  // Parameter defaults
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int ALEN_W      = 11;
  localparam logic [ALEN_W-1:0] ALEN_RESET = 11'd1024;

  // Counters kept in one column row: states, match bases, insert bases
  localparam int NUM_ROW_CNT = 11;
  localparam logic [3:0] IDX_STATE0  = 4'd0;
  localparam logic [3:0] IDX_MATCH0  = 4'd3;
  localparam logic [3:0] IDX_INSERT0 = 4'd7;

  // Transaction kinds
  localparam logic [1:0] KIND_ANC  = 2'd0;
  localparam logic [1:0] KIND_SEQ  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Read tables
  localparam logic [2:0] TBL_TRANS  = 3'd0;
  localparam logic [2:0] TBL_ANC    = 3'd1;
  localparam logic [2:0] TBL_STATE  = 3'd2;
  localparam logic [2:0] TBL_MATCH  = 3'd3;
  localparam logic [2:0] TBL_INSERT = 3'd4;

  // Status codes
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_COL  = 2'd1;
  localparam logic [1:0] STS_CHAR = 2'd2;
  localparam logic [1:0] STS_ADDR = 2'd3;

  // Character classes
  localparam logic [1:0] CLS_MATCH  = 2'd0;
  localparam logic [1:0] CLS_INSERT = 2'd1;
  localparam logic [1:0] CLS_DELETE = 2'd2;
  localparam logic [1:0] CLS_NONE   = 2'd3;

  localparam logic [2:0] BASE_NONE = 3'd4;

  // Characters
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LC   = 8'h63;
  localparam logic [7:0] CH_LG   = 8'h67;
  localparam logic [7:0] CH_LT   = 8'h74;
  localparam logic [7:0] CH_LZ   = 8'h7A;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } phca_fsm_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic       first_of_sequence;
    logic [9:0] start_column;
    logic [2:0] read_table;
    logic [9:0] read_row;
    logic [1:0] read_col;
  } phca_in_t;

  typedef struct packed {
    logic [31:0] count_value;
    logic [1:0]  status;
  } phca_out_t;

  // Row update request handed to the update unit
  typedef struct packed {
    logic       bump_state;
    logic [3:0] state_idx;
    logic       bump_base;
    logic [3:0] base_idx;
  } phca_upd_t;

  function automatic logic [2:0] base_of(input logic [7:0] ch);
    case (ch) inside
      CH_A, CH_LA: base_of = 3'd0;
      CH_C, CH_LC: base_of = 3'd1;
      CH_G, CH_LG: base_of = 3'd2;
      CH_T, CH_LT: base_of = 3'd3;
      default:     base_of = BASE_NONE;
    endcase
  endfunction

  function automatic logic [3:0] trans_idx(input logic [1:0] from_cls,
                                           input logic [1:0] to_cls);
    trans_idx = ({2'b00, from_cls} * 4'd3) + {2'b00, to_cls};
  endfunction

endpackage

FILE: rtl/core/phca_row_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phca_row_ram
// Column row memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module phca_row_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 352
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/phca_row_upd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phca_row_upd
// Saturating bump of up to two counters in one column row.
// ----------------------------------------------------------------------------
module phca_row_upd #(
  parameter int COUNT_BITS = 32
) (
  input  logic [phca_pkg::NUM_ROW_CNT*COUNT_BITS-1:0] row_in,
  input  phca_pkg::phca_upd_t                          upd,
  output logic [phca_pkg::NUM_ROW_CNT*COUNT_BITS-1:0] row_out
);
  import phca_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  always_comb begin
    for (int k = 0; k < NUM_ROW_CNT; k++) begin
      logic [COUNT_BITS-1:0] cur;
      logic                  hit;
      cur = row_in[k*COUNT_BITS +: COUNT_BITS];
      hit = (upd.bump_state && (upd.state_idx == 4'(k))) ||
            (upd.bump_base  && (upd.base_idx  == 4'(k)));
      row_out[k*COUNT_BITS +: COUNT_BITS] =
        (hit && (cur != CNT_MAX)) ? cur + 1'b1 : cur;
    end
  end

endmodule

FILE: rtl/core/profile_hmm_count_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_hmm_count_accumulator_unit
// Profile HMM training count accumulator: ancestor base histogram, 3x3
// transition histogram and per-column state / match-base / insert-base
// counters, with a read transaction that returns any counter.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ------------------------------
//  in_      input      in_valid / in_ready    phca_in_t  (kind, char, read)
//  out_     output     out_valid / out_ready  phca_out_t (count, status)
//  cfg_     input      cfg_wr_en              cfg_wr_data = ancestor_length
//
//  Each transaction reads its column row from the row RAM on the accept
//  edge, then in execute, once the output register is free, modifies and
//  writes back the row while the result is loaded into the output register.
//  The registered RAM read and the return to idle after each write-back
//  mean a new transaction is accepted only after the last is written back.
//  After reset a clearing pass writes zeros to all MAX_COLUMNS rows, one per
//  cycle; in_ready stays low until the pass finishes.
//  A result that is not taken holds the next transaction in its write-back
//  cycle; one transaction may be accepted while a result waits.
//
module profile_hmm_count_accumulator_unit #(
  parameter int MAX_COLUMNS = phca_pkg::MAX_COLUMNS_DEF,
  parameter int COUNT_BITS  = phca_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [10:0]         cfg_wr_data,
  // input transactions
  input  logic                in_valid,
  output logic                in_ready,
  input  phca_pkg::phca_in_t  in_data,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output phca_pkg::phca_out_t out_data
);
  import phca_pkg::*;

  // Address and column widths
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int VW    = (CW + 1 > ALEN_W) ? CW + 1 : ALEN_W;
  localparam int ROW_W = NUM_ROW_CNT * COUNT_BITS;
  localparam int EXT_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  localparam logic [VW-1:0]         MAX_V    = VW'(MAX_COLUMNS);
  localparam logic [CW-1:0]         CLR_LAST = CW'(MAX_COLUMNS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  phca_fsm_t              fsm_r, fsm_nxt;
  logic [CW-1:0]          clr_cnt_r;
  logic [ALEN_W-1:0]      alen_r;
  logic [VW-1:0]          seq_col_r, seq_col_nxt;
  logic [1:0]             prev_r, prev_nxt;
  logic [COUNT_BITS-1:0]  trans_cnt_r [9];
  logic [COUNT_BITS-1:0]  trans_cnt_nxt [9];
  logic [COUNT_BITS-1:0]  anc_cnt_r [4];
  logic [COUNT_BITS-1:0]  anc_cnt_nxt [4];

  // Transaction under work: payload and its column (or read row)
  phca_in_t               item_r;
  logic [VW-1:0]          col_r;
  logic [VW-1:0]          col_sel;

  logic                   out_valid_r;
  phca_out_t              out_data_r;
  phca_out_t              res;

  logic                   accept;
  logic                   exec_fire;

  // Row RAM ports
  logic                   ram_we;
  logic [CW-1:0]          ram_waddr;
  logic [ROW_W-1:0]       ram_wdata;
  logic [ROW_W-1:0]       ram_rdata;
  logic [ROW_W-1:0]       row_upd;
  logic                   row_we;
  phca_upd_t              upd;

  // Character decode and range checks
  logic                   is_up, is_lo, is_dash, ch_ok, counted;
  logic                   in_range;
  logic [1:0]             cls, eff_prev;
  logic [2:0]             base;
  logic [VW-1:0]          lim;
  logic [COUNT_BITS-1:0]  rd_cnt;
  logic [3:0]             rd_idx;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign accept    = in_valid && in_ready;
  assign exec_fire = (fsm_r == FSM_EXEC) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= FSM_CLEAR;
    end else begin
      fsm_r <= fsm_nxt;
    end
  end

  always_comb begin
    fsm_nxt  = fsm_r;
    in_ready = 1'b0;
    unique case (fsm_r)
      FSM_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) begin
          fsm_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          fsm_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (exec_fire) begin
          fsm_nxt = FSM_IDLE;
        end
      end
      default: fsm_nxt = FSM_IDLE;
    endcase
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (fsm_r == FSM_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r <= ALEN_RESET;
    end else if (cfg_wr_en) begin
      alen_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: pick the row to read
  // ---------------------------------------------------------------------------
  // A sequence character works on the running column (or its start column on
  // a new sequence); a read works on read_row.
  always_comb begin
    if (in_data.kind == KIND_READ) begin
      col_sel = VW'(in_data.read_row);
    end else if (in_data.first_of_sequence) begin
      col_sel = VW'(in_data.start_column);
    end else begin
      col_sel = seq_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      col_r  <= col_sel;
    end
  end

  phca_row_ram #(
    .DEPTH (MAX_COLUMNS),
    .AW    (CW),
    .DW    (ROW_W)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (col_sel[CW-1:0]),
    .rd_data (ram_rdata)
  );

  phca_row_upd #(
    .COUNT_BITS (COUNT_BITS)
  ) u_row_upd (
    .row_in  (ram_rdata),
    .upd     (upd),
    .row_out (row_upd)
  );

  // Clearing pass owns the write port until it finishes
  assign ram_we    = (fsm_r == FSM_CLEAR) || row_we;
  assign ram_waddr = (fsm_r == FSM_CLEAR) ? clr_cnt_r : col_r[CW-1:0];
  assign ram_wdata = (fsm_r == FSM_CLEAR) ? '0 : row_upd;

  // ---------------------------------------------------------------------------
  // Execute stage: classify, count, read out
  // ---------------------------------------------------------------------------
  assign is_up   = (item_r.char_code >= CH_A)  && (item_r.char_code <= CH_Z);
  assign is_lo   = (item_r.char_code >= CH_LA) && (item_r.char_code <= CH_LZ);
  assign is_dash = (item_r.char_code == CH_DASH);
  assign ch_ok   = is_up || is_lo || is_dash;
  assign cls     = is_up ? CLS_MATCH : (is_lo ? CLS_INSERT : CLS_DELETE);
  assign base    = base_of(item_r.char_code);
  assign counted = (cls == CLS_DELETE) || (base != BASE_NONE);
  // a new sequence has no previous class
  assign eff_prev = item_r.first_of_sequence ? CLS_NONE : prev_r;

  // column limit = min(ancestor_length, MAX_COLUMNS)
  assign lim      = (VW'(alen_r) < MAX_V) ? VW'(alen_r) : MAX_V;
  assign in_range = (col_r < lim);

  // counter picked by a column-table read
  always_comb begin
    case (item_r.read_table)
      TBL_MATCH:  rd_idx = IDX_MATCH0  + {2'b00, item_r.read_col};
      TBL_INSERT: rd_idx = IDX_INSERT0 + {2'b00, item_r.read_col};
      default:    rd_idx = IDX_STATE0  + {2'b00, item_r.read_col};
    endcase
  end

  always_comb begin
    seq_col_nxt   = seq_col_r;
    prev_nxt      = prev_r;
    trans_cnt_nxt = trans_cnt_r;
    anc_cnt_nxt   = anc_cnt_r;
    upd           = '0;
    row_we        = 1'b0;
    rd_cnt        = '0;
    res           = '0;
    if (exec_fire) begin
      unique case (item_r.kind)
        KIND_ANC: begin
          if (base != BASE_NONE) begin
            if (anc_cnt_r[base[1:0]] != CNT_MAX) begin
              anc_cnt_nxt[base[1:0]] = anc_cnt_r[base[1:0]] + 1'b1;
            end
          end else begin
            res.status = STS_CHAR;
          end
        end
        KIND_SEQ: begin
          // a new sequence is started even on a bad character
          seq_col_nxt = col_r;
          prev_nxt    = eff_prev;
          if (!ch_ok) begin
            res.status = STS_CHAR;
          end else begin
            if (eff_prev != CLS_NONE) begin
              if (trans_cnt_r[trans_idx(eff_prev, cls)] != CNT_MAX) begin
                trans_cnt_nxt[trans_idx(eff_prev, cls)] =
                  trans_cnt_r[trans_idx(eff_prev, cls)] + 1'b1;
              end
            end
            prev_nxt = cls;
            // non-ACGT letters count only as a transition
            if (counted) begin
              if (in_range) begin
                row_we         = 1'b1;
                upd.bump_state = 1'b1;
                upd.state_idx  = IDX_STATE0 + {2'b00, cls};
                if (cls == CLS_MATCH) begin
                  upd.bump_base = 1'b1;
                  upd.base_idx  = IDX_MATCH0 + {2'b00, base[1:0]};
                end else if (cls == CLS_INSERT) begin
                  upd.bump_base = 1'b1;
                  upd.base_idx  = IDX_INSERT0 + {2'b00, base[1:0]};
                end
              end else begin
                res.status = STS_COL;
              end
              // running column saturates at MAX_COLUMNS
              if ((cls != CLS_INSERT) && (col_r < MAX_V)) begin
                seq_col_nxt = col_r + 1'b1;
              end
            end
          end
        end
        KIND_READ: begin
          res.status = STS_ADDR;
          unique case (item_r.read_table) inside
            TBL_TRANS: begin
              if ((item_r.read_row < 10'd3) && (item_r.read_col != CLS_NONE)) begin
                rd_cnt     = trans_cnt_r[trans_idx(item_r.read_row[1:0],
                                                   item_r.read_col)];
                res.status = STS_OK;
              end
            end
            TBL_ANC: begin
              rd_cnt     = anc_cnt_r[item_r.read_col];
              res.status = STS_OK;
            end
            TBL_STATE: begin
              if (in_range && (item_r.read_col != CLS_NONE)) begin
                rd_cnt     = ram_rdata[rd_idx*COUNT_BITS +: COUNT_BITS];
                res.status = STS_OK;
              end
            end
            TBL_MATCH, TBL_INSERT: begin
              if (in_range) begin
                rd_cnt     = ram_rdata[rd_idx*COUNT_BITS +: COUNT_BITS];
                res.status = STS_OK;
              end
            end
            default: res.status = STS_ADDR;
          endcase
          res.count_value = 32'(EXT_W'(rd_cnt));
        end
        default: res.status = STS_ADDR;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence state and small histograms
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_col_r <= '0;
      prev_r    <= CLS_NONE;
      for (int i = 0; i < 9; i++) begin
        trans_cnt_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        anc_cnt_r[i] <= '0;
      end
    end else begin
      seq_col_r   <= seq_col_nxt;
      prev_r      <= prev_nxt;
      trans_cnt_r <= trans_cnt_nxt;
      anc_cnt_r   <= anc_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec_fire || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == FSM_CLEAR) |-> !in_ready)
    else $error("transaction accepted during clearing pass");

  a_row_write_at_fire: assert property (@(posedge clk) disable iff (!rst_n)
    row_we |-> (exec_fire && (item_r.kind == KIND_SEQ) && in_range))
    else $error("row write outside a sequence write-back");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fsm_r == FSM_EXEC))
    else $error("result appeared without an executed transaction");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (fsm_r == FSM_EXEC))
    else $error("accepted transaction did not enter execute");

endmodule
